// ===== rtl/core/tflc_pkg.sv =====
// Package for the thermal fan level controller: types, constants, speed table.
package tflc_pkg;

   localparam int CHECK_TICKS_DEF = 5;

   localparam int TEMP_W   = 8;
   localparam int SPEED_W  = 7;
   localparam int LEVEL_W  = 5;
   localparam int THR_W    = 7;
   localparam int MARGIN_W = 6;
   localparam int RISE_W   = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   localparam int NUM_LEVELS = 20;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 5'd19;
   localparam logic [SPEED_W-1:0] SPEED_MAX = 7'd99;
   localparam logic [TEMP_W-1:0]  FLOOR_LATCHED = 8'd255;

   // fan mode codes
   localparam logic [1:0] FAN_MODE_OFF    = 2'd0;
   localparam logic [1:0] FAN_MODE_FAST   = 2'd1;
   localparam logic [1:0] FAN_MODE_MEDIAN = 2'd2;
   localparam logic [1:0] FAN_MODE_SLOW   = 2'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FAN_MODE         = 3'd0,
      CSR_OFF_MARGIN       = 3'd1,
      CSR_THRESHOLD_FAST   = 3'd2,
      CSR_THRESHOLD_MEDIAN = 3'd3,
      CSR_THRESHOLD_SLOW   = 3'd4,
      CSR_OVERHEAT_LIMIT   = 3'd5,
      CSR_FPGA_RISE_MARGIN = 3'd6,
      CSR_MIN_ON_SPEED     = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [1:0]                 fan_mode;
      logic signed [MARGIN_W-1:0] off_margin;
      logic [THR_W-1:0]           threshold_fast;
      logic [THR_W-1:0]           threshold_median;
      logic [THR_W-1:0]           threshold_slow;
      logic [THR_W-1:0]           overheat_limit;
      logic [RISE_W-1:0]          fpga_rise_margin;
      logic [SPEED_W-1:0]         min_on_speed;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      fan_mode:         FAN_MODE_SLOW,
      off_margin:       -6'sd5,
      threshold_fast:   7'd60,
      threshold_median: 7'd70,
      threshold_slow:   7'd75,
      overheat_limit:   7'd105,
      fpga_rise_margin: 8'd10,
      min_on_speed:     7'd40
   };

   // everything carried from one tick to the next, except the check counter
   typedef struct packed {
      logic [SPEED_W-1:0] current_speed;
      logic [TEMP_W-1:0]  fpga_floor;
      logic               always_on;
      logic [SPEED_W-1:0] last_driven_speed;
      logic               last_driven_valid;
   } state_type;

   localparam state_type STATE_RESET = '0;

   typedef struct packed {
      logic               tick_done;
      logic [SPEED_W-1:0] fan_speed;
      logic               drive_write;
      logic               overheat;
      logic               always_on_latched;
   } result_type;

   function automatic logic [SPEED_W-1:0] level_speed(input logic [LEVEL_W-1:0] lv);
      logic [SPEED_W-1:0] s;
      case (lv)
         5'd0:  s = 7'd0;
         5'd1:  s = 7'd1;
         5'd2:  s = 7'd2;
         5'd3:  s = 7'd3;
         5'd4:  s = 7'd5;
         5'd5:  s = 7'd7;
         5'd6:  s = 7'd10;
         5'd7:  s = 7'd14;
         5'd8:  s = 7'd18;
         5'd9:  s = 7'd23;
         5'd10: s = 7'd28;
         5'd11: s = 7'd34;
         5'd12: s = 7'd40;
         5'd13: s = 7'd47;
         5'd14: s = 7'd54;
         5'd15: s = 7'd62;
         5'd16: s = 7'd71;
         5'd17: s = 7'd80;
         5'd18: s = 7'd90;
         5'd19: s = 7'd99;
         default: s = 7'd0;
      endcase
      return s;
   endfunction

   // speeds off the table map to level 0
   function automatic logic [LEVEL_W-1:0] speed_to_level(input logic [SPEED_W-1:0] s);
      logic [LEVEL_W-1:0] lv;
      lv = '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         if (level_speed(LEVEL_W'(i)) == s) begin
            lv = LEVEL_W'(i);
         end
      end
      return lv;
   endfunction

endpackage

// ===== rtl/core/tflc_if.sv =====
// Valid/ready channel interfaces for tick requests and tick results.
interface tflc_req_if
   import tflc_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [TEMP_W-1:0] cpu_temp;
   logic [TEMP_W-1:0] fpga_temp;

   modport source (output valid, output cpu_temp, output fpga_temp, input ready);
   modport sink   (input valid, input cpu_temp, input fpga_temp, output ready);
endinterface

interface tflc_rsp_if
   import tflc_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               tick_done;
   logic [SPEED_W-1:0] fan_speed;
   logic               drive_write;
   logic               overheat;
   logic               always_on_latched;

   modport source (output valid, output tick_done, output fan_speed, output drive_write,
                   output overheat, output always_on_latched, input ready);
   modport sink   (input valid, input tick_done, input fan_speed, input drive_write,
                   input overheat, input always_on_latched, output ready);
endinterface

// ===== rtl/core/thermal_fan_level_controller_core.sv =====
// Top level of the thermal fan level controller: CSRs, input and result registers.
//
// Usage:
//   req_if carries one control tick per word (cpu_temp, fpga_temp); rsp_if returns
//   exactly one result word per tick, in order. A word moves when valid and ready
//   are both high at a rising clock edge.
//   The csr_ port writes register csr_index with csr_wdata when csr_we is high;
//   write only while no tick is in flight.
// Timing: a request word passes the input register, then the result register; the tick
//   update sits between them in one pass, and while the result register is busy the
//   word waits in the input register.
// Throughput: one tick per cycle while results are taken; the speed/floor/counter state
//   loop closes in the single tick stage.
// Reset (synchronous, active high): CSRs take their default values, fan state
//   clears, both stages empty.
// Stall: a held result keeps its word; the input register still takes one more
//   word, then req ready drops until the result is taken.
module thermal_fan_level_controller_core
   import tflc_pkg::*;
#(
   parameter int CheckTicks = CHECK_TICKS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   tflc_req_if.sink              req_if,
   tflc_rsp_if.source            rsp_if
);

   localparam int CntW = $clog2(CheckTicks + 1);

   cfg_type            cfg_ff, cfg_in;
   state_type          state_ff, state_in;
   logic [CntW-1:0]    count_ff, count_in;
   logic               in_valid_ff;
   logic [TEMP_W-1:0]  cpu_ff;
   logic [TEMP_W-1:0]  fpga_ff;
   logic               rsp_valid_ff;
   result_type         rsp_ff, rsp_in;
   logic               advance;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_FAN_MODE:         cfg_in.fan_mode         = csr_wdata[1:0];
            CSR_OFF_MARGIN:       cfg_in.off_margin       = csr_wdata[MARGIN_W-1:0];
            CSR_THRESHOLD_FAST:   cfg_in.threshold_fast   = csr_wdata[THR_W-1:0];
            CSR_THRESHOLD_MEDIAN: cfg_in.threshold_median = csr_wdata[THR_W-1:0];
            CSR_THRESHOLD_SLOW:   cfg_in.threshold_slow   = csr_wdata[THR_W-1:0];
            CSR_OVERHEAT_LIMIT:   cfg_in.overheat_limit   = csr_wdata[THR_W-1:0];
            CSR_FPGA_RISE_MARGIN: cfg_in.fpga_rise_margin = csr_wdata[RISE_W-1:0];
            CSR_MIN_ON_SPEED:     cfg_in.min_on_speed     = csr_wdata[SPEED_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   // tick stage fires when it holds a word and the result register is free or its word is taken
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;

   tflc_tick #(
      .CheckTicks (CheckTicks)
   ) u_tick (
      .cfg       (cfg_ff),
      .state     (state_ff),
      .count     (count_ff),
      .cpu_temp  ($signed(cpu_ff)),
      .fpga_temp (fpga_ff),
      .state_nxt (state_in),
      .count_nxt (count_in),
      .result    (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         state_ff     <= STATE_RESET;
         count_ff     <= '0;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         if (req_if.valid && req_if.ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            state_ff     <= state_in;
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         cpu_ff  <= req_if.cpu_temp;
         fpga_ff <= req_if.fpga_temp;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_if.valid             = rsp_valid_ff;
   assign rsp_if.tick_done         = rsp_ff.tick_done;
   assign rsp_if.fan_speed         = rsp_ff.fan_speed;
   assign rsp_if.drive_write       = rsp_ff.drive_write;
   assign rsp_if.overheat          = rsp_ff.overheat;
   assign rsp_if.always_on_latched = rsp_ff.always_on_latched;

endmodule

// ===== rtl/core/tflc_tick.sv =====
// Combinational tick update: level step, floor tracking, rise check, drive compare.
module tflc_tick
   import tflc_pkg::*;
#(
   parameter int CheckTicks = CHECK_TICKS_DEF,
   localparam int CntW = $clog2(CheckTicks + 1)
) (
   input  cfg_type                  cfg,
   input  state_type                state,
   input  logic [CntW-1:0]          count,
   input  logic signed [TEMP_W-1:0] cpu_temp,
   input  logic [TEMP_W-1:0]        fpga_temp,
   output state_type                state_nxt,
   output logic [CntW-1:0]          count_nxt,
   output result_type               result
);

   logic [THR_W-1:0]     thr;
   logic [LEVEL_W-1:0]   base_lv;
   logic signed [8:0]    diff;
   logic signed [8:0]    lv_sum;
   logic signed [8:0]    lv_held;
   logic signed [8:0]    margin_ext;
   logic [LEVEL_W-1:0]   lv;
   logic [SPEED_W-1:0]   speed_lvl;
   logic [SPEED_W-1:0]   min_speed;
   logic [SPEED_W-1:0]   speed;
   logic [TEMP_W-1:0]    floor_upd;
   logic [TEMP_W:0]      rise_limit;
   logic [CntW-1:0]      count_inc;
   logic                 latch;

   always_comb begin
      case (cfg.fan_mode)
         FAN_MODE_FAST:   thr = cfg.threshold_fast;
         FAN_MODE_MEDIAN: thr = cfg.threshold_median;
         FAN_MODE_SLOW:   thr = cfg.threshold_slow;
         default:         thr = cfg.threshold_slow;
      endcase
   end

   assign base_lv    = speed_to_level(state.current_speed);
   assign diff       = 9'(cpu_temp) - $signed({2'b00, thr});
   assign lv_sum     = $signed({4'b0000, base_lv}) + diff;
   assign margin_ext = 9'(cfg.off_margin);

   // a running fan stops only when the drop reaches the off margin, else holds level 1
   always_comb begin
      if (base_lv != '0 && lv_sum < 9'sd1) begin
         lv_held = (diff <= margin_ext) ? 9'sd0 : 9'sd1;
      end else begin
         lv_held = lv_sum;
      end
      if (lv_held < 9'sd0) begin
         lv = '0;
      end else if (lv_held > $signed({4'b0000, LEVEL_MAX})) begin
         lv = LEVEL_MAX;
      end else begin
         lv = lv_held[LEVEL_W-1:0];
      end
   end

   assign speed_lvl = (cfg.fan_mode == FAN_MODE_OFF) ? '0 : level_speed(lv);
   assign min_speed = (cfg.min_on_speed > SPEED_MAX) ? SPEED_MAX : cfg.min_on_speed;
   assign floor_upd = (state.fpga_floor == '0 || fpga_temp < state.fpga_floor)
                      ? fpga_temp : state.fpga_floor;
   assign rise_limit = {1'b0, floor_upd} + {1'b0, cfg.fpga_rise_margin};
   assign count_inc  = count + CntW'(1);

   always_comb begin
      state_nxt = state;
      count_nxt = count;
      latch     = 1'b0;
      speed     = speed_lvl;
      state_nxt.fpga_floor = floor_upd;
      if (state.always_on) begin
         if (speed_lvl < min_speed) begin
            speed = min_speed;
         end
      end else begin
         count_nxt = count_inc;
         if (count_inc >= CntW'(CheckTicks)) begin
            count_nxt = '0;
            if ({1'b0, fpga_temp} > rise_limit) begin
               latch = 1'b1;
               state_nxt.always_on  = 1'b1;
               state_nxt.fpga_floor = FLOOR_LATCHED;
            end
         end
      end
      state_nxt.current_speed = speed;

      result.tick_done         = 1'b1;
      result.fan_speed         = speed;
      result.overheat          = ({1'b0, cpu_temp[THR_W-1:0]} >= {1'b0, cfg.overheat_limit});
      result.always_on_latched = latch;
      result.drive_write       = !state.last_driven_valid ||
                                 state.last_driven_speed != speed;
      state_nxt.last_driven_speed = speed;
      state_nxt.last_driven_valid = 1'b1;

      // failed CPU read: nothing moves, report the held speed
      if (cpu_temp[TEMP_W-1]) begin
         state_nxt = state;
         count_nxt = count;
         result    = '{tick_done: 1'b0, fan_speed: state.current_speed,
                       drive_write: 1'b0, overheat: 1'b0, always_on_latched: 1'b0};
      end
   end

endmodule
